[rtl/core/fmv_pkg.sv]
package fmv_pkg;

	// Result verdict codes, carried on m_tuser
	typedef enum logic [2:0] {
		VERDICT_OK          = 3'd0,
		VERDICT_OK_UNKNOWN  = 3'd1,
		VERDICT_BAD_MAGIC   = 3'd2,
		VERDICT_BAD_CSUM    = 3'd3,
		VERDICT_TRUNCATED   = 3'd4
	} verdict_t;

	// Configuration register indexes
	localparam logic [1:0] REG_MAGIC     = 2'd0;
	localparam logic [1:0] REG_SENSITIVE = 2'd1;
	localparam logic [1:0] REG_NORMAL    = 2'd2;
	localparam logic [1:0] REG_CHECK_EN  = 2'd3;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;

	// Reset values of the configuration registers
	localparam logic [7:0] MAGIC_RESET     = 8'hCC;
	localparam logic [7:0] SENSITIVE_RESET = 8'h40;
	localparam logic [7:0] NORMAL_RESET    = 8'h00;
	localparam logic       CHECK_EN_RESET  = 1'b1;

	// Checksum bytes are summed as this fill value
	localparam logic [7:0] CSUM_FILL = 8'hCC;

	// Result tdata: payload_length[15:0], options_byte[23:16], computed_checksum[39:24]
	localparam int OUT_DATA_W = 40;
	localparam int OUT_USER_W = 3;
	localparam int CSUM_LSB   = 24;

endpackage

[rtl/core/framed_message_validator_core.sv]
// Framed message validator.
// Input stream (s_*): one byte per request on s_tdata. A request with s_tlast
// high marks the sender closing the stream; its data byte is ignored and a
// message cut off during its data field is reported as truncated.
// Output stream (m_*): at most one result per message, the verdict on m_tuser
// and length, options byte and computed checksum on m_tdata.
// Configuration: cfg_we writes cfg_data into register cfg_index in the same
// edge; writes are to be made only while the block is idle, a rule on the
// user that the block itself does not enforce. Result path: a byte in the
// input register advances when the output is free; results are registered.
// Throughput: one byte per cycle while the output is not stalled, set by the
// single end-around-carry adder that folds each byte into the running sum
// between the input register and the result register.
// Stall: when m_tready is low with a result waiting, the input register holds
// one more byte and s_tready then drops until the result is taken.
// Reset: arst_n clears the message state, the output valid and loads the
// configuration defaults; the block then waits for a header.
module framed_message_validator_core #(
	parameter int HEADER_BYTES = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,  // stream_byte[7:0]
	input  logic                            s_tlast,  // stream_end
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// payload_length[15:0], options_byte[23:16], computed_checksum[39:24]
	output logic [fmv_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic [fmv_pkg::OUT_USER_W-1:0]  m_tuser,  // verdict[2:0]
	input  logic                            cfg_we,
	input  logic [fmv_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [fmv_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int CntW = $clog2(HEADER_BYTES);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_DATA,
		PH_BADMAGIC
	} phase_t;

	// configuration
	logic [7:0] magic_q, sens_q, norm_q;
	logic       chk_en_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	// message state
	phase_t            phase_q, phase_n;
	logic [CntW-1:0]   cnt_q, cnt_n;
	logic [7:0]        opt_q, opt_n;
	logic [15:0]       len_q, len_n;
	logic [15:0]       chk_q, chk_n;
	logic [15:0]       rem_q, rem_n;
	logic [15:0]       sum_q, sum_n;
	logic [7:0]        pend_q, pend_n;
	logic              odd_q, odd_n;

	// datapath
	logic              advance;
	logic              hdr_mode, first;
	logic [15:0]       sum_in;
	logic [7:0]        pend_in;
	logic              odd_in;
	logic [7:0]        counted;
	logic [15:0]       addend;
	logic [16:0]       raw_sum;
	logic [15:0]       add_res;
	logic [15:0]       cs_final;
	fmv_pkg::verdict_t final_vrd;

	logic                            emit;
	fmv_pkg::verdict_t               vrd;
	logic [15:0]                     cs_out;
	logic                            m_valid_q;
	logic [fmv_pkg::OUT_DATA_W-1:0]  m_data_q;
	logic [fmv_pkg::OUT_USER_W-1:0]  m_user_q;

	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q  <= fmv_pkg::MAGIC_RESET;
			sens_q   <= fmv_pkg::SENSITIVE_RESET;
			norm_q   <= fmv_pkg::NORMAL_RESET;
			chk_en_q <= fmv_pkg::CHECK_EN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fmv_pkg::REG_MAGIC:     magic_q  <= cfg_data;
				fmv_pkg::REG_SENSITIVE: sens_q   <= cfg_data;
				fmv_pkg::REG_NORMAL:    norm_q   <= cfg_data;
				fmv_pkg::REG_CHECK_EN:  chk_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			end_s1  <= s_tlast;
		end
	end

	// Sum operands; the first header byte starts from a cleared sum
	assign hdr_mode = (phase_q != PH_DATA);
	assign first    = hdr_mode && (cnt_q == '0);
	assign sum_in   = first ? 16'h0000 : sum_q;
	assign pend_in  = first ? 8'h00 : pend_q;
	assign odd_in   = first ? 1'b0 : odd_q;
	assign counted  = (hdr_mode && (cnt_q == CntW'(4) || cnt_q == CntW'(5)))
		? fmv_pkg::CSUM_FILL : byte_s1;

	// Even byte: word completes and is added. Odd byte: the byte alone is added,
	// which is the final fold should the message end here.
	assign addend   = odd_in ? {counted, pend_in} : {8'h00, counted};
	assign raw_sum  = {1'b0, sum_in} + {1'b0, addend};
	assign add_res  = raw_sum[15:0] + {15'd0, raw_sum[16]};
	assign cs_final = ~add_res;

	always_comb begin
		final_vrd = fmv_pkg::VERDICT_OK;
		if (chk_en_q) begin
			if (opt_n == sens_q) begin
				final_vrd = (cs_final == chk_n) ? fmv_pkg::VERDICT_OK
					: fmv_pkg::VERDICT_BAD_CSUM;
			end else if (opt_n != norm_q) begin
				final_vrd = fmv_pkg::VERDICT_OK_UNKNOWN;
			end
		end
	end

	always_comb begin
		phase_n = phase_q;
		cnt_n   = cnt_q;
		opt_n   = opt_q;
		len_n   = len_q;
		chk_n   = chk_q;
		rem_n   = rem_q;
		sum_n   = sum_q;
		pend_n  = pend_q;
		odd_n   = odd_q;
		emit    = 1'b0;
		vrd     = fmv_pkg::VERDICT_OK;
		cs_out  = 16'h0000;

		if (end_s1) begin
			if (phase_q == PH_DATA) begin
				emit = 1'b1;
				vrd  = fmv_pkg::VERDICT_TRUNCATED;
			end
			phase_n = PH_HEADER;
			cnt_n   = '0;
			rem_n   = 16'h0000;
			sum_n   = 16'h0000;
			pend_n  = 8'h00;
			odd_n   = 1'b0;
		end else begin
			sum_n  = odd_in ? add_res : sum_in;
			pend_n = odd_in ? pend_in : counted;
			odd_n  = !odd_in;
			unique case (phase_q)
				PH_DATA: begin
					rem_n = rem_q - 16'd1;
					if (rem_n == 16'h0000) begin
						emit    = 1'b1;
						vrd     = final_vrd;
						cs_out  = cs_final;
						phase_n = PH_HEADER;
						cnt_n   = '0;
						sum_n   = 16'h0000;
						pend_n  = 8'h00;
						odd_n   = 1'b0;
					end
				end
				default: begin
					if (first) begin
						phase_n = (byte_s1 == magic_q) ? PH_HEADER : PH_BADMAGIC;
						rem_n   = 16'h0000;
					end
					if (cnt_q == CntW'(1)) opt_n = byte_s1;
					if (cnt_q == CntW'(2)) len_n = {byte_s1, 8'h00};
					if (cnt_q == CntW'(3)) len_n = {len_q[15:8], byte_s1};
					if (cnt_q == CntW'(4)) chk_n = {8'h00, byte_s1};
					if (cnt_q == CntW'(5)) chk_n = {byte_s1, chk_q[7:0]};
					if (cnt_q == CntW'(HEADER_BYTES - 1)) begin
						cnt_n = '0;
						if (phase_n == PH_BADMAGIC || len_n == 16'h0000) begin
							emit    = 1'b1;
							vrd     = (phase_n == PH_BADMAGIC)
								? fmv_pkg::VERDICT_BAD_MAGIC : final_vrd;
							cs_out  = (phase_n == PH_BADMAGIC) ? 16'h0000 : cs_final;
							phase_n = PH_HEADER;
							rem_n   = 16'h0000;
							sum_n   = 16'h0000;
							pend_n  = 8'h00;
							odd_n   = 1'b0;
						end else begin
							phase_n = PH_DATA;
							rem_n   = len_n;
						end
					end else begin
						cnt_n = cnt_q + CntW'(1);
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			cnt_q     <= '0;
			opt_q     <= 8'h00;
			len_q     <= 16'h0000;
			chk_q     <= 16'h0000;
			rem_q     <= 16'h0000;
			sum_q     <= 16'h0000;
			pend_q    <= 8'h00;
			odd_q     <= 1'b0;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
			m_user_q  <= '0;
		end else begin
			if (advance) begin
				phase_q <= phase_n;
				cnt_q   <= cnt_n;
				opt_q   <= opt_n;
				len_q   <= len_n;
				chk_q   <= chk_n;
				rem_q   <= rem_n;
				sum_q   <= sum_n;
				pend_q  <= pend_n;
				odd_q   <= odd_n;
			end
			if (advance && emit) begin
				m_valid_q <= 1'b1;
				m_data_q  <= {cs_out, opt_n, len_n};
				m_user_q  <= vrd;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

endmodule

[rtl/core/fmv_checker.sv]
module fmv_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [fmv_pkg::OUT_DATA_W-1:0]  m_tdata,
	input logic [fmv_pkg::OUT_USER_W-1:0]  m_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// input backpressure only comes from a stalled result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("s_tready low without output stall");

	// bad magic and truncation carry no checksum
	a_no_csum: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == fmv_pkg::VERDICT_BAD_MAGIC
			|| m_tuser == fmv_pkg::VERDICT_TRUNCATED)
		|-> m_tdata[fmv_pkg::OUT_DATA_W-1:fmv_pkg::CSUM_LSB] == 16'h0000)
		else $error("nonzero checksum on aborted message");

	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= fmv_pkg::VERDICT_TRUNCATED)
		else $error("verdict out of range");

endmodule

bind framed_message_validator_core fmv_checker u_fmv_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
